[hw/rtl/pfm_pkg.sv]
// ----------------------------------------------------------------------------
// Packet filter matcher package
// Shared constants and types for the packet filter matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfm_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PADDR_W     = 6;
    localparam int PDATA_W     = 64;
    localparam int REG_IDX_W   = 3;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MATCH_PROTOCOL = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MATCH_PORT     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MATCH_HOST     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TEXT_PATTERN   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TEXT_LENGTH    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_HEX_PATTERN    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_HEX_LENGTH     = 3'd7;

    localparam int EN_PROTOCOL = 0;
    localparam int EN_PORT     = 1;
    localparam int EN_HOST     = 2;
    localparam int EN_TEXT     = 3;
    localparam int EN_HEX      = 4;

    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [4:0]  enable_mask;
        logic [7:0]  match_protocol;
        logic [15:0] match_port;
        logic [31:0] match_host;
        logic [63:0] text_pattern;
        logic [3:0]  text_length;
        logic [63:0] hex_pattern;
        logic [3:0]  hex_length;
    } t_cfg;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic text;
        logic hex;
    } t_cell_match;

endpackage

`default_nettype wire

[hw/rtl/pfm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Packet filter matcher configuration registers
// APB-style register file holding the filter settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfm_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pfm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [pfm_pkg::PDATA_W-1:0] pwdata,
    output logic      [pfm_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output pfm_pkg::t_cfg                    o_cfg
);

    pfm_pkg::t_cfg                  r_cfg;
    logic [pfm_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[pfm_pkg::PADDR_W-1:3];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                pfm_pkg::REG_ENABLE_MASK:    r_cfg.enable_mask    <= pwdata[4:0];
                pfm_pkg::REG_MATCH_PROTOCOL: r_cfg.match_protocol <= pwdata[7:0];
                pfm_pkg::REG_MATCH_PORT:     r_cfg.match_port     <= pwdata[15:0];
                pfm_pkg::REG_MATCH_HOST:     r_cfg.match_host     <= pwdata[31:0];
                pfm_pkg::REG_TEXT_PATTERN:   r_cfg.text_pattern   <= pwdata[63:0];
                pfm_pkg::REG_TEXT_LENGTH:    r_cfg.text_length    <= pwdata[3:0];
                pfm_pkg::REG_HEX_PATTERN:    r_cfg.hex_pattern    <= pwdata[63:0];
                pfm_pkg::REG_HEX_LENGTH:     r_cfg.hex_length     <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pfm_pkg::REG_ENABLE_MASK:    prdata = {59'd0, r_cfg.enable_mask};
            pfm_pkg::REG_MATCH_PROTOCOL: prdata = {56'd0, r_cfg.match_protocol};
            pfm_pkg::REG_MATCH_PORT:     prdata = {48'd0, r_cfg.match_port};
            pfm_pkg::REG_MATCH_HOST:     prdata = {32'd0, r_cfg.match_host};
            pfm_pkg::REG_TEXT_PATTERN:   prdata = r_cfg.text_pattern;
            pfm_pkg::REG_TEXT_LENGTH:    prdata = {60'd0, r_cfg.text_length};
            pfm_pkg::REG_HEX_PATTERN:    prdata = r_cfg.hex_pattern;
            pfm_pkg::REG_HEX_LENGTH:     prdata = {60'd0, r_cfg.hex_length};
            default:                     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/pfm_match_cell.sv]
// ----------------------------------------------------------------------------
// Packet filter matcher prefix cell
// One pattern position: records whether the pattern prefix ending here
// matches the payload run ending at the newest word, for both patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfm_match_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pfm_pkg::t_cell_ctl   i_ctl,
    input  wire logic [7:0]           i_byte,
    input  wire logic [7:0]           i_text_byte,
    input  wire logic [7:0]           i_hex_byte,
    input  wire pfm_pkg::t_cell_match i_prev,
    output pfm_pkg::t_cell_match      o_match,
    output pfm_pkg::t_cell_match      o_next
);

    pfm_pkg::t_cell_match r_match;
    pfm_pkg::t_cell_match n_match;

    always_comb begin
        n_match.text = i_prev.text & (i_byte == i_text_byte);
        n_match.hex  = i_prev.hex  & (i_byte == i_hex_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= '0;
        end else if (i_ctl.clear) begin
            r_match <= '0;
        end else if (i_ctl.shift) begin
            r_match <= n_match;
        end
    end

    assign o_match = r_match;
    assign o_next  = n_match;

endmodule

`default_nettype wire

[hw/rtl/packet_filter_matcher_top.sv]
// ----------------------------------------------------------------------------
// Packet filter matcher
// Header filters, payload pattern search and verdict output.
// ----------------------------------------------------------------------------
// Each packet is a header word followed by payload words; the word with last
// set yields one accept verdict. The block takes one word every cycle while
// o_stall is low: the payload search is a row of eight prefix cells, one per
// pattern byte, each updated once per payload word. A verdict is registered
// in the output register, or in a skid register while the output is held;
// input goes on while one verdict waits to be taken and stalls while the skid is full.
// Registers sit at byte address 8*i on a 64-bit APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module packet_filter_matcher_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pfm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [pfm_pkg::PDATA_W-1:0] pwdata,
    output logic      [pfm_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_op,
    input  wire logic [7:0]                  i_protocol,
    input  wire logic                        i_ports_present,
    input  wire logic [15:0]                 i_source_port,
    input  wire logic [15:0]                 i_dest_port,
    input  wire logic                        i_has_addresses,
    input  wire logic [31:0]                 i_src_addr,
    input  wire logic [31:0]                 i_dst_addr,
    input  wire logic                        i_carries_payload,
    input  wire logic [7:0]                  i_payload_byte,
    input  wire logic                        i_last,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_accept
);

    localparam int PM = pfm_pkg::PATTERN_MAX;

    pfm_pkg::t_cfg        cfg;
    pfm_pkg::t_cell_ctl   cell_ctl;
    pfm_pkg::t_cell_match cell_prev [PM];
    pfm_pkg::t_cell_match cell_reg  [PM];
    pfm_pkg::t_cell_match cell_next [PM];

    logic [PM-1:0]                text_next;
    logic [PM-1:0]                hex_next;
    logic [3:0]                   text_lm1;
    logic [3:0]                   hex_lm1;
    logic                         text_hit;
    logic                         hex_hit;
    logic                         in_take;
    logic                         is_hdr;
    logic                         is_pay;
    logic                         hdr_ok;
    logic                         text_ok;
    logic                         hex_ok;
    logic                         res_valid;
    logic                         res_accept;
    logic                         out_take;

    logic r_header_pass;
    logic r_payload_present;
    logic r_text_found;
    logic r_hex_found;
    logic r_out_valid;
    logic r_out_accept;
    logic r_skid_valid;
    logic r_skid_accept;

    pfm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign in_take = i_valid & ~o_stall;
    assign is_hdr  = in_take & (i_op == pfm_pkg::OP_HEADER);
    assign is_pay  = in_take & (i_op == pfm_pkg::OP_PAYLOAD);

    assign cell_ctl.shift = is_pay;
    assign cell_ctl.clear = is_hdr | (in_take & i_last);

    for (genvar j = 0; j < PM; j++) begin : g_cell
        if (j == 0) begin : g_first
            assign cell_prev[j] = '{text: 1'b1, hex: 1'b1};
        end else begin : g_rest
            assign cell_prev[j] = cell_reg[j-1];
        end

        pfm_match_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_byte      (i_payload_byte),
            .i_text_byte (cfg.text_pattern[8*j +: 8]),
            .i_hex_byte  (cfg.hex_pattern[8*j +: 8]),
            .i_prev      (cell_prev[j]),
            .o_match     (cell_reg[j]),
            .o_next      (cell_next[j])
        );

        assign text_next[j] = cell_next[j].text;
        assign hex_next[j]  = cell_next[j].hex;
    end

    assign text_lm1 = 4'(cfg.text_length - 4'd1);
    assign hex_lm1  = 4'(cfg.hex_length - 4'd1);
    assign text_hit = (cfg.text_length != 4'd0) && (cfg.text_length <= 4'(PM))
                      && text_next[text_lm1[pfm_pkg::IDX_W-1:0]];
    assign hex_hit  = (cfg.hex_length != 4'd0) && (cfg.hex_length <= 4'(PM))
                      && hex_next[hex_lm1[pfm_pkg::IDX_W-1:0]];

    always_comb begin
        hdr_ok = 1'b1;
        if (cfg.enable_mask[pfm_pkg::EN_PROTOCOL] && (i_protocol != cfg.match_protocol)) begin
            hdr_ok = 1'b0;
        end
        if (cfg.enable_mask[pfm_pkg::EN_PORT] && (!i_ports_present ||
            ((i_source_port != cfg.match_port) && (i_dest_port != cfg.match_port)))) begin
            hdr_ok = 1'b0;
        end
        if (cfg.enable_mask[pfm_pkg::EN_HOST] && (!i_has_addresses ||
            ((i_src_addr != cfg.match_host) && (i_dst_addr != cfg.match_host)))) begin
            hdr_ok = 1'b0;
        end
    end

    assign text_ok = ~cfg.enable_mask[pfm_pkg::EN_TEXT] |
                     (r_payload_present & (r_text_found | text_hit));
    assign hex_ok  = ~cfg.enable_mask[pfm_pkg::EN_HEX] |
                     (r_payload_present & (r_hex_found | hex_hit));

    assign res_valid = in_take & i_last;
    always_comb begin
        if (i_op == pfm_pkg::OP_HEADER) begin
            res_accept = hdr_ok & ~cfg.enable_mask[pfm_pkg::EN_TEXT] &
                         ~cfg.enable_mask[pfm_pkg::EN_HEX];
        end else begin
            res_accept = r_header_pass & text_ok & hex_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_pass     <= 1'b0;
            r_payload_present <= 1'b0;
            r_text_found      <= 1'b0;
            r_hex_found       <= 1'b0;
        end else if (in_take) begin
            if (i_last) begin
                r_header_pass     <= 1'b0;
                r_payload_present <= 1'b0;
                r_text_found      <= 1'b0;
                r_hex_found       <= 1'b0;
            end else if (i_op == pfm_pkg::OP_HEADER) begin
                r_header_pass     <= hdr_ok;
                r_payload_present <= i_carries_payload;
                r_text_found      <= 1'b0;
                r_hex_found       <= 1'b0;
            end else begin
                r_text_found      <= r_text_found | text_hit;
                r_hex_found       <= r_hex_found | hex_hit;
            end
        end
    end

    assign out_take = r_out_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid  <= 1'b1;
                r_out_accept <= res_accept;
            end else begin
                r_skid_valid  <= 1'b1;
                r_skid_accept <= res_accept;
            end
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_out_accept <= r_skid_accept;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    assign o_stall  = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_accept = r_out_accept;

endmodule

`default_nettype wire

[sim/tb_packet_filter_matcher_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet filter matcher testbench
// Drives header and payload words into the matcher, programs its registers
// over the APB-style port and checks every accept verdict against a
// cycle-free model of the filters kept inside the bench. A short directed
// pass covers the filter extremes and the pattern corner cases, then random
// packets (well-formed, abandoned and headerless) run under three idling
// mixes, followed by a long receiver hold that fills the block.
// ----------------------------------------------------------------------------

module tb_packet_filter_matcher_top;
    import pfm_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 650;
    localparam int ROUND_WORDS    = 110;

    typedef struct packed {
        logic        op;
        logic [7:0]  protocol;
        logic        ports_present;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        has_addresses;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic        carries_payload;
        logic [7:0]  payload_byte;
        logic        last;
    } pkt_word_t;

    logic                i_clk;
    logic                i_rst_n           = 1'b0;
    logic                psel              = 1'b0;
    logic                penable           = 1'b0;
    logic                pwrite            = 1'b0;
    logic [PADDR_W-1:0]  paddr             = '0;
    logic [PDATA_W-1:0]  pwdata            = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                i_valid           = 1'b0;
    logic                o_stall;
    logic                i_op              = 1'b0;
    logic [7:0]          i_protocol        = '0;
    logic                i_ports_present   = 1'b0;
    logic [15:0]         i_source_port     = '0;
    logic [15:0]         i_dest_port       = '0;
    logic                i_has_addresses   = 1'b0;
    logic [31:0]         i_src_addr        = '0;
    logic [31:0]         i_dst_addr        = '0;
    logic                i_carries_payload = 1'b0;
    logic [7:0]          i_payload_byte    = '0;
    logic                i_last            = 1'b0;
    logic                o_valid;
    logic                i_stall           = 1'b0;
    logic                o_accept;

    packet_filter_matcher_top i_dut (.*);

    // Filter model state and its copy of the registers.
    t_cfg        cfg_model = '0;
    logic        header_ok = 1'b0;
    logic        payload_flag = 1'b0;
    logic        text_hit = 1'b0;
    logic        hex_hit = 1'b0;
    logic [55:0] history = '0;
    logic [3:0]  byte_count = '0;
    logic        expected_verdicts[$];
    logic [7:0]  packet_body[$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned hold_left = 0;
    int          quiet_cycles = 0;
    int          words_sent = 0;
    int          verdicts_checked = 0;
    int          accepts_seen = 0;
    int          errors = 0;
    logic        verdict_want;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic pattern_hit(logic [63:0] window, logic [3:0] seen,
                                         logic [63:0] pattern, logic [3:0] len);
        logic [63:0] tail;
        logic [63:0] mask;
        if (len == 0 || len > PATTERN_MAX || seen < len) begin
            return 1'b0;
        end
        tail = window >> (8 * (8 - len));
        mask = (len == 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
        return tail == (pattern & mask);
    endfunction

    task automatic clear_packet_state();
        header_ok    = 1'b0;
        payload_flag = 1'b0;
        text_hit     = 1'b0;
        hex_hit      = 1'b0;
        history      = '0;
        byte_count   = '0;
    endtask

    task automatic advance_filter(input pkt_word_t w);
        logic [63:0] window;
        logic        ok;
        if (w.op == OP_HEADER) begin
            clear_packet_state();
            ok = 1'b1;
            if (cfg_model.enable_mask[EN_PROTOCOL] && w.protocol != cfg_model.match_protocol) begin
                ok = 1'b0;
            end
            if (cfg_model.enable_mask[EN_PORT] && (!w.ports_present ||
                (w.source_port != cfg_model.match_port &&
                 w.dest_port != cfg_model.match_port))) begin
                ok = 1'b0;
            end
            if (cfg_model.enable_mask[EN_HOST] && (!w.has_addresses ||
                (w.src_addr != cfg_model.match_host && w.dst_addr != cfg_model.match_host))) begin
                ok = 1'b0;
            end
            header_ok    = ok;
            payload_flag = w.carries_payload;
        end else begin
            window = {w.payload_byte, history};
            if (byte_count < 8) begin
                byte_count++;
            end
            if (pattern_hit(window, byte_count, cfg_model.text_pattern, cfg_model.text_length)) begin
                text_hit = 1'b1;
            end
            if (pattern_hit(window, byte_count, cfg_model.hex_pattern, cfg_model.hex_length)) begin
                hex_hit = 1'b1;
            end
            history = window[63:8];
        end
        if (w.last) begin
            ok = header_ok;
            if (cfg_model.enable_mask[EN_TEXT] && !(payload_flag && text_hit)) begin
                ok = 1'b0;
            end
            if (cfg_model.enable_mask[EN_HEX] && !(payload_flag && hex_hit)) begin
                ok = 1'b0;
            end
            expected_verdicts.push_back(ok);
            clear_packet_state();
        end
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE_MASK:    cfg_model.enable_mask    = value[4:0];
            REG_MATCH_PROTOCOL: cfg_model.match_protocol = value[7:0];
            REG_MATCH_PORT:     cfg_model.match_port     = value[15:0];
            REG_MATCH_HOST:     cfg_model.match_host     = value[31:0];
            REG_TEXT_PATTERN:   cfg_model.text_pattern   = value;
            REG_TEXT_LENGTH:    cfg_model.text_length    = value[3:0];
            REG_HEX_PATTERN:    cfg_model.hex_pattern    = value;
            REG_HEX_LENGTH:     cfg_model.hex_length     = value[3:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input t_cfg c);
        write_register(REG_ENABLE_MASK, 64'(c.enable_mask));
        write_register(REG_MATCH_PROTOCOL, 64'(c.match_protocol));
        write_register(REG_MATCH_PORT, 64'(c.match_port));
        write_register(REG_MATCH_HOST, 64'(c.match_host));
        write_register(REG_TEXT_PATTERN, c.text_pattern);
        write_register(REG_TEXT_LENGTH, 64'(c.text_length));
        write_register(REG_HEX_PATTERN, c.hex_pattern);
        write_register(REG_HEX_LENGTH, 64'(c.hex_length));
    endtask

    task automatic send_word(input pkt_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_op              <= w.op;
        i_protocol        <= w.protocol;
        i_ports_present   <= w.ports_present;
        i_source_port     <= w.source_port;
        i_dest_port       <= w.dest_port;
        i_has_addresses   <= w.has_addresses;
        i_src_addr        <= w.src_addr;
        i_dst_addr        <= w.dst_addr;
        i_carries_payload <= w.carries_payload;
        i_payload_byte    <= w.payload_byte;
        i_last            <= w.last;
        do @(posedge i_clk); while (o_stall);
        advance_filter(w);
        words_sent++;
    endtask

    task automatic wait_for_verdicts();
        i_valid <= 1'b0;
        while (expected_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic pkt_word_t random_word();
        logic [127:0] r;
        r = {$urandom(), $urandom(), $urandom(), $urandom()};
        return r[$bits(pkt_word_t)-1:0];
    endfunction

    function automatic pkt_word_t make_header(logic [7:0] protocol, logic ports_present,
                                              logic [15:0] source_port, logic [15:0] dest_port,
                                              logic has_addresses, logic [31:0] src_addr,
                                              logic [31:0] dst_addr, logic carries_payload,
                                              logic last);
        pkt_word_t w;
        w                 = random_word();
        w.op              = OP_HEADER;
        w.protocol        = protocol;
        w.ports_present   = ports_present;
        w.source_port     = source_port;
        w.dest_port       = dest_port;
        w.has_addresses   = has_addresses;
        w.src_addr        = src_addr;
        w.dst_addr        = dst_addr;
        w.carries_payload = carries_payload;
        w.last            = last;
        return w;
    endfunction

    function automatic pkt_word_t make_byte(logic [7:0] value, logic last);
        pkt_word_t w;
        w              = random_word();
        w.op           = OP_PAYLOAD;
        w.payload_byte = value;
        w.last         = last;
        return w;
    endfunction

    function automatic pkt_word_t random_header();
        pkt_word_t w;
        w    = random_word();
        w.op = OP_HEADER;
        if ($urandom_range(99) < 60) w.protocol = cfg_model.match_protocol;
        w.ports_present = ($urandom_range(99) < 85);
        if ($urandom_range(99) < 45) w.source_port = cfg_model.match_port;
        if ($urandom_range(99) < 45) w.dest_port = cfg_model.match_port;
        w.has_addresses = ($urandom_range(99) < 85);
        if ($urandom_range(99) < 45) w.src_addr = cfg_model.match_host;
        if ($urandom_range(99) < 45) w.dst_addr = cfg_model.match_host;
        w.carries_payload = ($urandom_range(99) < 85);
        w.last            = 1'b0;
        return w;
    endfunction

    function automatic logic [3:0] pattern_length();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 4'd0;
        if (r < 16) return 4'($urandom_range(15, 9));
        return 4'($urandom_range(8, 1));
    endfunction

    function automatic t_cfg random_config();
        t_cfg c;
        c.enable_mask    = 5'($urandom_range(31));
        c.match_protocol = 8'($urandom());
        c.match_port     = 16'($urandom());
        c.match_host     = $urandom();
        for (int k = 0; k < 8; k++) begin
            c.text_pattern[8*k +: 8] = 8'($urandom_range(126, 32));
        end
        c.text_length = pattern_length();
        c.hex_pattern = {$urandom(), $urandom()};
        c.hex_length  = pattern_length();
        if ($urandom_range(9) == 0) begin
            c.enable_mask = '1;
            c.text_length = 4'd8;
            c.hex_length  = 4'd8;
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        int lane;
        r    = $urandom_range(99);
        lane = $urandom_range(7);
        if (r < 35) return cfg_model.text_pattern[8*lane +: 8];
        if (r < 60) return cfg_model.hex_pattern[8*lane +: 8];
        return 8'($urandom());
    endfunction

    function automatic void plant_pattern(logic [63:0] pattern, logic [3:0] len);
        int at;
        if (len == 0 || len > PATTERN_MAX || packet_body.size() < int'(len)) return;
        at = $urandom_range(packet_body.size() - int'(len));
        for (int k = 0; k < int'(len); k++) begin
            packet_body[at + k] = pattern[8*k +: 8];
        end
    endfunction

    // A lone closing header leaves no packet open before the registers change.
    task automatic close_open_packet();
        send_word(make_header(8'h00, 1'b0, 16'h0, 16'h0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b1));
    endtask

    // Kinds below 6 are payload words with no header, 6 to 11 are packets
    // abandoned without a closing word, the rest are well-formed packets.
    task automatic send_random_packet();
        int        kind;
        int        n_bytes;
        pkt_word_t w;
        kind    = $urandom_range(99);
        n_bytes = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(14);
        packet_body = {};
        for (int i = 0; i < n_bytes; i++) begin
            packet_body.push_back(pick_byte());
        end
        if ($urandom_range(99) < 40) plant_pattern(cfg_model.text_pattern, cfg_model.text_length);
        if ($urandom_range(99) < 30) plant_pattern(cfg_model.hex_pattern, cfg_model.hex_length);
        if (kind >= 6) begin
            w      = random_header();
            w.last = (n_bytes == 0) && (kind >= 12);
            send_word(w);
        end
        for (int i = 0; i < n_bytes; i++) begin
            w = make_byte(packet_body[i],
                          (i == n_bytes - 1) && (kind >= 12 || (kind < 6 && kind % 2 == 0)));
            send_word(w);
        end
    endtask

    task automatic test_after_reset();
        send_word(make_byte(8'h5A, 1'b1));
        send_word(make_header(8'h11, 1'b0, 16'h0, 16'h0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b1));
        wait_for_verdicts();
    endtask

    task automatic test_header_filters();
        t_cfg c;
        c = '0;
        c.enable_mask[EN_PROTOCOL] = 1'b1;
        c.enable_mask[EN_PORT]     = 1'b1;
        c.enable_mask[EN_HOST]     = 1'b1;
        c.match_protocol = '1;
        c.match_port     = '1;
        c.match_host     = '1;
        apply_config(c);
        send_word(make_header(8'hFF, 1'b1, 16'hFFFF, 16'h0, 1'b1, 32'h0, 32'hFFFF_FFFF,
                              1'b1, 1'b1));
        send_word(make_header(8'hFE, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 1'b0, 1'b1));
        send_word(make_header(8'hFF, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF,
                              32'h0, 1'b1, 1'b1));
        wait_for_verdicts();
        c.match_protocol = '0;
        c.match_port     = '0;
        c.match_host     = '0;
        apply_config(c);
        send_word(make_header(8'h00, 1'b1, 16'hFFFF, 16'h0, 1'b1, 32'h0, 32'hFFFF_FFFF,
                              1'b0, 1'b1));
        send_word(make_header(8'h00, 1'b1, 16'h0, 16'h0, 1'b0, 32'h0, 32'h0, 1'b1, 1'b1));
        wait_for_verdicts();
    endtask

    task automatic test_payload_search();
        t_cfg c;
        c = '0;
        c.enable_mask[EN_TEXT] = 1'b1;
        c.enable_mask[EN_HEX]  = 1'b1;
        // The first pattern byte sits in the lowest lane, so the literal reads backwards.
        c.text_pattern = "hgfedcba";
        c.text_length  = 4'd8;
        c.hex_pattern  = 64'h0000_0000_0000_00FF;
        c.hex_length   = 4'd2;
        apply_config(c);
        send_word(make_header(8'h06, 1'b1, 16'h50, 16'h1F90, 1'b1, 32'h0A00_0001,
                              32'h0A00_0002, 1'b1, 1'b0));
        for (int k = 0; k < 8; k++) begin
            send_word(make_byte(c.text_pattern[8*k +: 8], 1'b0));
        end
        send_word(make_byte(8'hFF, 1'b0));
        send_word(make_byte(8'h00, 1'b1));
        send_word(make_header(8'h06, 1'b1, 16'h0, 16'h0, 1'b1, 32'h0, 32'h0, 1'b1, 1'b1));
        send_word(make_header(8'h11, 1'b0, 16'h0, 16'h0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0));
        send_word(make_byte(8'hFF, 1'b0));
        send_word(make_byte(8'h00, 1'b1));
        wait_for_verdicts();
        c.text_length = 4'd0;
        c.hex_length  = 4'd9;
        apply_config(c);
        send_word(make_header(8'h06, 1'b1, 16'h0, 16'h0, 1'b1, 32'h0, 32'h0, 1'b1, 1'b0));
        send_word(make_byte(8'hFF, 1'b0));
        send_word(make_byte(8'h00, 1'b1));
        wait_for_verdicts();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int phase_end;
        int round_end;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        phase_end     = words_sent + PHASE_WORDS;
        while (words_sent < phase_end) begin
            close_open_packet();
            wait_for_verdicts();
            apply_config(random_config());
            round_end = words_sent + ROUND_WORDS;
            while (words_sent < round_end) begin
                send_random_packet();
            end
        end
        wait_for_verdicts();
    endtask

    task automatic test_backpressure();
        pkt_word_t w;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        close_open_packet();
        wait_for_verdicts();
        apply_config(random_config());
        hold_left <= HOLD_CYCLES;
        repeat (40) begin
            w      = random_header();
            w.last = 1'($urandom_range(1));
            send_word(w);
            if (!w.last) begin
                send_word(make_byte(pick_byte(), 1'b1));
            end
        end
        wait_for_verdicts();
    endtask

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, actual accept=%0b",
                         $time, o_accept);
                errors++;
            end else begin
                verdict_want = expected_verdicts.pop_front();
                if (o_accept !== verdict_want) begin
                    $display("%0t: accept mismatch, expected %0b, actual %0b",
                             $time, verdict_want, o_accept);
                    errors++;
                end
                verdicts_checked++;
                if (verdict_want) accepts_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word has moved for %0d cycles, %0d verdicts outstanding",
                         $time, quiet_cycles, expected_verdicts.size());
                $display("tb_packet_filter_matcher_top: FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_header_filters();
        test_payload_search();
        test_random_traffic(31, 52);
        test_random_traffic(52, 31);
        test_random_traffic(0, 0);
        test_backpressure();
        wait_for_verdicts();
        $display("Sent %0d words and checked %0d verdicts, %0d of them accepts.",
                 words_sent, verdicts_checked, accepts_seen);
        $display("Traffic mixed header and pattern filters, broken packets and a long output hold.");
        if (errors == 0) begin
            $display("tb_packet_filter_matcher_top: PASS");
        end else begin
            $display("tb_packet_filter_matcher_top: FAIL");
        end
        $finish;
    end

endmodule
